/* src/sst_pkg.sv */
// Shared codes, state encoding and controller/datapath interface types.
package sst_pkg;

	// Item kinds carried on the input tuser
	localparam logic [1:0] OP_DATA     = 2'd0;
	localparam logic [1:0] OP_LOAD_PAT = 2'd1;
	localparam logic [1:0] OP_LOAD_REP = 2'd2;
	localparam logic [1:0] OP_LOAD_TBL = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_PLEN = 2'd1;
	localparam logic [1:0] CFG_RLEN = 2'd2;
	localparam logic [1:0] CFG_RALL = 2'd3;

	// Operating modes
	localparam logic MODE_SUBST = 1'b0;
	localparam logic MODE_XLATE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XL_RD,
		ST_XL_EMIT,
		ST_SB_RD,
		ST_SB_CHK,
		ST_DM_RD,
		ST_DM_EMIT,
		ST_RP_RD,
		ST_RP_EMIT,
		ST_END,
		ST_FL_RD,
		ST_FL_EMIT,
		ST_FIN
	} sst_state_t;

	typedef enum logic [1:0] {
		SRC_SUB,
		SRC_REP,
		SRC_PAT,
		SRC_TBL
	} emit_src_t;

	// Controller to datapath
	typedef struct packed {
		logic      accept;
		logic      k_inc;
		logic      k_clr;
		logic      start_inc;
		logic      j_clr;
		logic      j_inc;
		logic      set_partial;
		logic      m_zero;
		logic      fr_set;
		logic      emit;
		emit_src_t src;
		logic      push;
	} sst_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mode;
		logic active;
		logic eq;
		logic seg_end;
		logic full;
		logic start_last;
		logic r_zero;
		logic rep_end;
		logic last;
		logic m_nz;
		logic flush_end;
		logic emit_ok;
		logic push_ok;
	} sst_status_t;

endpackage

/* src/sst_ctrl.sv */
// Controller state machine sequencing table lookup, match, replacement, flush and output push.
module sst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_op,
	output logic                in_ready,
	input  sst_pkg::sst_status_t st,
	output sst_pkg::sst_cmd_t    cmd
);
	import sst_pkg::*;

	sst_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.src  = SRC_SUB;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && in_op == OP_DATA) begin
					if (st.mode == MODE_XLATE) state_d = ST_XL_RD;
					else if (st.active) state_d = ST_SB_RD;
					else state_d = ST_DM_RD;
				end
			end
			ST_XL_RD: state_d = ST_XL_EMIT;
			ST_XL_EMIT: begin
				cmd.emit = 1'b1;
				cmd.src  = SRC_TBL;
				if (st.emit_ok) state_d = ST_END;
			end
			ST_SB_RD: state_d = ST_SB_CHK;
			ST_SB_CHK: begin
				if (st.eq) begin
					if (st.seg_end) begin
						if (st.full) begin
							cmd.fr_set = 1'b1;
							cmd.m_zero = 1'b1;
							cmd.j_clr  = 1'b1;
							state_d    = st.r_zero ? ST_END : ST_RP_RD;
						end else begin
							cmd.set_partial = 1'b1;
							state_d         = ST_END;
						end
					end else begin
						cmd.k_inc = 1'b1;
						state_d   = ST_SB_RD;
					end
				end else begin
					// mismatch: release the byte at the current start
					cmd.emit = 1'b1;
					cmd.src  = SRC_SUB;
					if (st.emit_ok) begin
						cmd.start_inc = 1'b1;
						cmd.k_clr     = 1'b1;
						if (st.start_last) begin
							cmd.m_zero = 1'b1;
							state_d    = ST_END;
						end else begin
							state_d = ST_SB_RD;
						end
					end
				end
			end
			ST_DM_RD: state_d = ST_DM_EMIT;
			ST_DM_EMIT: begin
				cmd.emit = 1'b1;
				cmd.src  = SRC_SUB;
				if (st.emit_ok) begin
					cmd.start_inc = 1'b1;
					if (st.start_last) begin
						cmd.m_zero = 1'b1;
						state_d    = ST_END;
					end else begin
						state_d = ST_DM_RD;
					end
				end
			end
			ST_RP_RD: state_d = ST_RP_EMIT;
			ST_RP_EMIT: begin
				cmd.emit = 1'b1;
				cmd.src  = SRC_REP;
				if (st.emit_ok) begin
					cmd.j_inc = 1'b1;
					state_d   = st.rep_end ? ST_END : ST_RP_RD;
				end
			end
			ST_END: begin
				if (st.last && st.m_nz) begin
					cmd.k_clr = 1'b1;
					state_d   = ST_FL_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FL_RD: state_d = ST_FL_EMIT;
			ST_FL_EMIT: begin
				cmd.emit = 1'b1;
				cmd.src  = SRC_PAT;
				if (st.emit_ok) begin
					cmd.k_inc = 1'b1;
					state_d   = st.flush_end ? ST_FIN : ST_FL_RD;
				end
			end
			ST_FIN: begin
				cmd.push = 1'b1;
				if (st.push_ok) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* src/sst_dp.sv */
// Datapath: configuration, pattern/replacement/table stores, match counters, output stage.
module sst_dp #(
	parameter int MAX_PATTERN = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [5:0]           cfg_data,
	input  logic [1:0]           in_op,
	input  logic [7:0]           in_index,
	input  logic [7:0]           in_value,
	input  logic                 in_last,
	input  sst_pkg::sst_cmd_t    cmd,
	output sst_pkg::sst_status_t st,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 out_has,
	output logic                 out_last
);
	import sst_pkg::*;

	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int CW = LW + 1;

	// Configuration registers
	logic       mode_q, rall_q;
	logic [5:0] plen_q, rlen_q;

	// Match state and counters
	logic [LW-1:0] m_q;
	logic          fr_q;
	logic [7:0]    c_q;
	logic          last_q;
	logic [CW-1:0] start_q, k_q, j_q;
	logic [7:0]    sfirst_q;

	// Stores and registered read data
	logic [7:0] pat_mem [MAX_PATTERN];
	logic [7:0] rep_mem [MAX_PATTERN];
	logic [7:0] tbl_mem [256];
	logic [255:0] tbl_vld_q;
	logic [7:0] rd1_q, rd2_q, rep_rd_q, tbl_rd, tbl_raw_q;
	logic       tbl_hit_q;

	// Output stage: one pending byte plus the output register
	logic       pend_valid_q;
	logic [7:0] pend_byte_q;
	logic       out_valid_q, out_has_q, out_last_q;
	logic [7:0] out_byte_q;

	logic [LW-1:0] plen_eff, rlen_eff, m_eff;
	logic [CW-1:0] len_l, sk, seg_len;
	logic [7:0]    s_byte, emit_byte;
	logic          emit_ok, push_ok, do_emit, do_push, load_out;
	logic          pat_we, rep_we, tbl_we, idx_ok;

	// Effective lengths with clamping
	always_comb begin
		if (plen_q == 6'd0) plen_eff = LW'(1);
		else if (32'(plen_q) > MAX_PATTERN) plen_eff = LW'(MAX_PATTERN);
		else plen_eff = LW'(plen_q);
		if (32'(rlen_q) > MAX_PATTERN) rlen_eff = LW'(MAX_PATTERN);
		else rlen_eff = LW'(rlen_q);
	end

	// Window arithmetic over held bytes plus the new byte
	assign m_eff   = (m_q >= plen_eff) ? '0 : m_q;
	assign len_l   = CW'(m_eff) + CW'(1);
	assign sk      = start_q + k_q;
	assign seg_len = len_l - start_q;
	assign s_byte  = (sk == CW'(m_eff)) ? c_q : rd1_q;
	assign tbl_rd  = tbl_hit_q ? tbl_raw_q : c_q;

	always_comb begin
		unique case (cmd.src)
			SRC_SUB: emit_byte = (k_q == '0) ? s_byte : sfirst_q;
			SRC_REP: emit_byte = rep_rd_q;
			SRC_PAT: emit_byte = rd2_q;
			SRC_TBL: emit_byte = tbl_rd;
			default: emit_byte = s_byte;
		endcase
	end

	assign emit_ok  = !pend_valid_q || !out_valid_q || out_ready;
	assign push_ok  = !out_valid_q || out_ready;
	assign do_emit  = cmd.emit && emit_ok;
	assign do_push  = cmd.push && push_ok;
	assign load_out = (do_emit && pend_valid_q) || (do_push && (last_q || pend_valid_q));

	// Status to the controller
	always_comb begin
		st            = '0;
		st.mode       = mode_q;
		st.active     = rall_q || !fr_q;
		st.eq         = (s_byte == rd2_q);
		st.seg_end    = (sk + CW'(1)) == len_l;
		st.full       = seg_len == CW'(plen_eff);
		st.start_last = (start_q + CW'(1)) == len_l;
		st.r_zero     = (rlen_eff == '0);
		st.rep_end    = (j_q + CW'(1)) == CW'(rlen_eff);
		st.last       = last_q;
		st.m_nz       = (m_q != '0);
		st.flush_end  = (k_q + CW'(1)) == CW'(m_q);
		st.emit_ok    = emit_ok;
		st.push_ok    = push_ok;
	end

	// Load decode
	assign idx_ok = 32'(in_index) < MAX_PATTERN;
	assign pat_we = cmd.accept && in_op == OP_LOAD_PAT && idx_ok;
	assign rep_we = cmd.accept && in_op == OP_LOAD_REP && idx_ok;
	assign tbl_we = cmd.accept && in_op == OP_LOAD_TBL;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SUBST;
			plen_q <= 6'd1;
			rlen_q <= 6'd0;
			rall_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[0];
				CFG_PLEN: plen_q <= cfg_data;
				CFG_RLEN: rlen_q <= cfg_data;
				CFG_RALL: rall_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Held prefix length and the only-first flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q  <= '0;
			fr_q <= 1'b0;
		end else begin
			if (cmd.accept && in_op == OP_LOAD_PAT) m_q <= '0;
			else if (cfg_we && (cfg_index == CFG_MODE || cfg_index == CFG_PLEN)) m_q <= '0;
			else if (cmd.m_zero) m_q <= '0;
			else if (cmd.set_partial) m_q <= LW'(seg_len);
			else if (do_push && last_q) m_q <= '0;
			if (cmd.fr_set) fr_q <= 1'b1;
			else if (do_push && last_q) fr_q <= 1'b0;
		end
	end

	// Item registers and scan counters
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			c_q     <= in_value;
			last_q  <= in_last;
			start_q <= '0;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			if (cmd.start_inc) start_q <= start_q + CW'(1);
			if (cmd.k_clr) k_q <= '0;
			else if (cmd.k_inc) k_q <= k_q + CW'(1);
			if (cmd.j_clr) j_q <= '0;
			else if (cmd.j_inc) j_q <= j_q + CW'(1);
		end
		if (k_q == '0) sfirst_q <= s_byte;
	end

	// Pattern and replacement stores
	always_ff @(posedge clk) begin
		if (pat_we) pat_mem[in_index[AW-1:0]] <= in_value;
		if (rep_we) rep_mem[in_index[AW-1:0]] <= in_value;
		rd1_q    <= pat_mem[sk[AW-1:0]];
		rd2_q    <= pat_mem[k_q[AW-1:0]];
		rep_rd_q <= rep_mem[j_q[AW-1:0]];
	end

	// Translate table, identity until an entry is loaded
	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[in_index] <= in_value;
		tbl_raw_q <= tbl_mem[c_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
			tbl_hit_q <= 1'b0;
		end else begin
			if (tbl_we) tbl_vld_q[in_index] <= 1'b1;
			tbl_hit_q <= tbl_vld_q[c_q];
		end
	end

	// Pending byte and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (do_emit) pend_valid_q <= 1'b1;
			else if (do_push) pend_valid_q <= 1'b0;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) pend_byte_q <= emit_byte;
		if (load_out) begin
			out_byte_q <= pend_valid_q ? pend_byte_q : 8'd0;
			out_has_q  <= pend_valid_q;
			out_last_q <= cmd.push && last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_has   = out_has_q;
	assign out_last  = out_last_q;

	// Held prefix is always shorter than the pattern
	a_prefix_short: assert property (@(posedge clk) disable iff (!arst_n)
		m_q == '0 || m_q < plen_eff)
		else $error("held prefix not shorter than pattern");

	// End of buffer leaves nothing pending and nothing held
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && last_q |=> !pend_valid_q && m_q == '0)
		else $error("state left after end of buffer");

	// An accepted emit always lands in the pending slot
	a_emit_pend: assert property (@(posedge clk) disable iff (!arst_n)
		do_emit |=> pend_valid_q)
		else $error("emitted byte lost");

endmodule

/* src/stream_substitute_translate.sv */
// Top level: streaming pattern substitute / byte translate block.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata {value, index}, tuser op, tlast last
// m_axis    out  tvalid/tready          tdata out_byte, tuser has_byte, tlast out_last
// cfg       in   cfg_valid/cfg_ready    cfg_index register, cfg_data value
//
// Loads are taken in the idle state, which they do not leave. A translated byte reads
// the table, is emitted, then closes out. A substitute byte compares pattern bytes
// over each fallback start, then releases bytes or emits the replacement, and closes out.
// Pattern reads go through one registered two-port store.
// Reset clears the controller, the held prefix and the table valid bits at once.
// Results park in a pending byte and an output register; a stalled output holds the FSM.
module stream_substitute_translate #(
	parameter int MAX_PATTERN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] index, [15:8] value
	input  logic [1:0]  s_axis_tuser,   // [1:0] op
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic [0:0]  m_axis_tuser,   // [0] has_byte
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data
);
	import sst_pkg::*;

	sst_cmd_t    cmd;
	sst_status_t st;
	logic        has_byte;

	assign cfg_ready = 1'b1;

	sst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	sst_dp #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_op     (s_axis_tuser),
		.in_index  (s_axis_tdata[7:0]),
		.in_value  (s_axis_tdata[15:8]),
		.in_last   (s_axis_tlast),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_has   (has_byte),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tuser[0] = has_byte;

endmodule
